// ===== rtl/pde_pkg.sv =====
// shared types and constants for the path difference energy block
package pde_pkg;

    // fixed field widths
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = 19;  // |third difference| < 2^18
    localparam int SQ_W        = 37;  // a square is at most 2^36
    localparam int SQ_SUM_W    = SQ_W + 2;
    localparam int SUM_W       = 63;
    localparam int ACC_W       = SUM_W + 1;
    localparam int HIST_POINTS = 3;
    localparam int AXES_MAX    = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic        [SQ_W-1:0]    t_sq;
    typedef logic        [SUM_W-1:0]   t_sum;
    typedef logic        [1:0]         t_order;
    typedef logic        [1:0]         t_seen;

    // difference order codes
    localparam t_order ORDER_ZERO  = 2'd0;
    localparam t_order ORDER_VEL   = 2'd1;
    localparam t_order ORDER_ACC   = 2'd2;
    localparam t_order ORDER_JERK  = 2'd3;
    localparam t_order ORDER_RESET = ORDER_JERK;

    localparam t_seen SEEN_MAX = 2'd3;
    localparam t_sum  SUM_MAX  = {SUM_W{1'b1}};

endpackage

// ===== rtl/pde_point_if.sv =====
// point channel: one control point per word
interface pde_point_if
    import pde_pkg::*;
;
    logic   valid;
    logic   ready;
    t_coord coord_x;
    t_coord coord_y;
    t_coord coord_z;
    logic   last_point;

    modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

// ===== rtl/pde_sum_if.sv =====
// result channel: one sum of squares per path
interface pde_sum_if
    import pde_pkg::*;
;
    logic valid;
    logic ready;
    t_sum sum_of_squares;

    modport source (output valid, sum_of_squares, input ready);
    modport sink   (input valid, sum_of_squares, output ready);
endinterface

// ===== rtl/pde_cfg_if.sv =====
// configuration write channel for the difference order register
interface pde_cfg_if
    import pde_pkg::*;
;
    logic   valid;
    logic   ready;
    t_order diff_order;

    modport source (output valid, diff_order, input ready);
    modport sink   (input valid, diff_order, output ready);
endinterface

// ===== rtl/path_difference_energy.sv =====
// top level: sum of squared finite differences along a path
//
// Takes one control point per cycle on i_pt and, for the word marked last_point,
// returns the saturating sum of squared velocity, acceleration or jerk differences
// (selected by diff_order, 0 acts as 1) on o_sum, then starts a new path. Three
// stages: the difference is formed and registered at accept, squared into the
// square register, and accumulated in the third, which registers the sum in the
// output word. One point per cycle is sustained; i_pt.ready drops only while a
// finished sum waits in the output register and another last point has reached
// the accumulator stage. Paths shorter than order+1 points give 0.
module path_difference_energy
    import pde_pkg::*;
#(
    parameter int DIMS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pde_cfg_if.sink     i_cfg,
    pde_point_if.sink   i_pt,
    pde_sum_if.source   o_sum
);

    // configuration
    t_order r_order;

    // history and path state
    t_coord r_hist [HIST_POINTS][DIMS];
    t_seen  r_points_seen;

    // stage 1: differences
    logic   r_s1_valid;
    logic   r_s1_last;
    t_diff  r_s1_diff [DIMS];

    // stage 2: squares
    logic   r_s2_valid;
    logic   r_s2_last;
    t_sq    r_s2_sq [DIMS];

    // stage 3: accumulator and output word
    t_sum   r_acc;
    logic   r_out_valid;
    t_sum   r_out_sum;

    logic   in_acc;
    logic   s2_consume;
    logic   s2_free;
    logic   s1_free;
    t_order eff_order;
    logic   use_window;
    t_coord cur [AXES_MAX];
    t_diff  n_diff [DIMS];
    logic signed [2*DIFF_W-1:0] n_sq_full [DIMS];
    logic   [SQ_SUM_W-1:0] n_sq_sum;
    logic   [ACC_W-1:0]    acc_add;
    t_sum   n_acc;

    // handshakes and pipeline flow
    assign s2_consume  = r_s2_valid && !(r_s2_last && r_out_valid && !o_sum.ready);
    assign s2_free     = !r_s2_valid || s2_consume;
    assign s1_free     = !r_s1_valid || s2_free;
    assign i_pt.ready  = s1_free;
    assign in_acc      = i_pt.valid && s1_free;
    assign i_cfg.ready = 1'b1;
    assign o_sum.valid = r_out_valid;
    assign o_sum.sum_of_squares = r_out_sum;

    // finite difference of the incoming point
    always_comb begin
        t_diff e0, e1, e2, e3;
        cur[0] = i_pt.coord_x;
        cur[1] = i_pt.coord_y;
        cur[2] = i_pt.coord_z;
        eff_order  = (r_order == ORDER_ZERO) ? ORDER_VEL : r_order;
        use_window = (r_points_seen >= eff_order);
        for (int a = 0; a < DIMS; a++) begin
            e0 = {{(DIFF_W-COORD_W){cur[a][COORD_W-1]}}, cur[a]};
            e1 = {{(DIFF_W-COORD_W){r_hist[0][a][COORD_W-1]}}, r_hist[0][a]};
            e2 = {{(DIFF_W-COORD_W){r_hist[1][a][COORD_W-1]}}, r_hist[1][a]};
            e3 = {{(DIFF_W-COORD_W){r_hist[2][a][COORD_W-1]}}, r_hist[2][a]};
            case (eff_order)
                ORDER_ACC:  n_diff[a] = e0 - (e1 + e1) + e2;
                ORDER_JERK: n_diff[a] = e0 - (e1 + e1 + e1) + (e2 + e2 + e2) - e3;
                default:    n_diff[a] = e0 - e1;
            endcase
            if (!use_window) begin
                n_diff[a] = '0;
            end
        end
    end

    // squares of the registered differences
    always_comb begin
        for (int a = 0; a < DIMS; a++) begin
            n_sq_full[a] = r_s1_diff[a] * r_s1_diff[a];
        end
    end

    // saturating accumulate
    always_comb begin
        n_sq_sum = '0;
        for (int a = 0; a < DIMS; a++) begin
            n_sq_sum = n_sq_sum + SQ_SUM_W'(r_s2_sq[a]);
        end
        acc_add = {1'b0, r_acc} + ACC_W'(n_sq_sum);
        n_acc   = acc_add[ACC_W-1] ? SUM_MAX : acc_add[SUM_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order       <= ORDER_RESET;
            r_points_seen <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_acc         <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_order <= i_cfg.diff_order;
            end
            if (in_acc) begin
                if (i_pt.last_point) begin
                    r_points_seen <= '0;
                end else if (r_points_seen != SEEN_MAX) begin
                    r_points_seen <= r_points_seen + t_seen'(1);
                end
            end
            if (s1_free) begin
                r_s1_valid <= in_acc;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_consume) begin
                r_acc <= r_s2_last ? '0 : n_acc;
            end
            if (s2_consume && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_pt.last_point) begin
            for (int a = 0; a < DIMS; a++) begin
                r_hist[2][a] <= r_hist[1][a];
                r_hist[1][a] <= r_hist[0][a];
                r_hist[0][a] <= cur[a];
            end
        end
        if (s1_free) begin
            r_s1_last <= i_pt.last_point;
            r_s1_diff <= n_diff;
        end
        if (s2_free) begin
            r_s2_last <= r_s1_last;
            for (int a = 0; a < DIMS; a++) begin
                r_s2_sq[a] <= n_sq_full[a][SQ_W-1:0];
            end
        end
        if (s2_consume && r_s2_last) begin
            r_out_sum <= n_acc;
        end
    end

    // a blocked last word stays in the square stage
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_last && r_out_valid && !o_sum.ready |=> r_s2_valid && r_s2_last)
        else $error("blocked last word left the square stage");

    // a new sum only follows a last word in the accumulator stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid ##1 r_out_valid |-> $past(r_s2_valid && r_s2_last))
        else $error("sum produced without a last word");

    // a last point starts a new path
    a_path_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_pt.last_point |=> r_points_seen == '0)
        else $error("point count not cleared after last point");

endmodule

// ===== dv/tb_top.sv =====
// testbench for path_difference_energy: random and directed paths checked against a predictor
`timescale 1ns / 100ps

module tb_top
    import pde_pkg::*;
;

    localparam int          DIMS          = 3;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASES        = 24;
    localparam int          PHASE_POINTS  = 33;
    localparam logic [63:0] SAT_LIMIT     = {1'b0, SUM_MAX};

    // expected sums of squared differences, one per finished path
    class path_energy_sb;
        int          dims;
        t_order      order_q;
        t_coord      hist [HIST_POINTS][AXES_MAX];  // [0] is the newest previous point
        t_seen       seen;
        logic [63:0] energy;
        t_sum        pending_sums [$];
        int unsigned fail_count;

        function new(int d);
            dims       = d;
            order_q    = ORDER_RESET;
            fail_count = 0;
            clear_path();
        endfunction

        function void clear_path();
            foreach (hist[h, a]) hist[h][a] = '0;
            seen   = '0;
            energy = '0;
        endfunction

        function void set_order(t_order value);
            order_q = value;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            fail_count++;
        endtask

        // one accepted point: add its squared differences, emit on the last word
        task note_point(t_coord x, t_coord y, t_coord z, logic last);
            t_coord      cur [AXES_MAX];
            t_order      eff;
            longint      d;
            logic [63:0] sq;
            cur[0] = x;
            cur[1] = y;
            cur[2] = z;
            eff = (order_q == ORDER_ZERO) ? ORDER_VEL : order_q;
            if (seen >= eff) begin
                for (int a = 0; a < dims; a++) begin
                    case (eff)
                        ORDER_VEL: d = longint'(cur[a]) - longint'(hist[0][a]);
                        ORDER_ACC: d = longint'(cur[a]) - 2 * longint'(hist[0][a])
                                       + longint'(hist[1][a]);
                        default:   d = longint'(cur[a]) - 3 * longint'(hist[0][a])
                                       + 3 * longint'(hist[1][a]) - longint'(hist[2][a]);
                    endcase
                    sq = 64'(d * d);
                    if (energy > SAT_LIMIT - sq) begin
                        energy = SAT_LIMIT;
                    end else begin
                        energy = energy + sq;
                    end
                end
            end
            if (last) begin
                pending_sums.push_back(energy[SUM_W-1:0]);
                clear_path();
            end else begin
                for (int h = HIST_POINTS - 1; h > 0; h--) begin
                    hist[h] = hist[h-1];
                end
                hist[0] = cur;
                if (seen != SEEN_MAX) seen++;
            end
        endtask

        task check_sum(t_sum got);
            t_sum want;
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("sum %0d with no path finished", got));
            end else begin
                want = pending_sums.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("sum_of_squares got %0d expected %0d",
                                              got, want));
                end
            end
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    int unsigned   src_idle_pct;
    int unsigned   sink_idle_pct;
    path_energy_sb sb;

    pde_cfg_if   cfg_bus ();
    pde_point_if pt_bus ();
    pde_sum_if   sum_bus ();

    path_difference_energy #(
        .DIMS (DIMS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pt    (pt_bus),
        .o_sum   (sum_bus)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("path_difference_energy test failed");
        $finish;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        sum_bus.ready = ($urandom_range(99) >= sink_idle_pct);
    end

    // monitor: config writes, accepted points and returned sums
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) sb.set_order(cfg_bus.diff_order);
            if (pt_bus.valid && pt_bus.ready) begin
                sb.note_point(pt_bus.coord_x, pt_bus.coord_y, pt_bus.coord_z,
                              pt_bus.last_point);
            end
            if (sum_bus.valid && sum_bus.ready) sb.check_sum(sum_bus.sum_of_squares);
        end
    end

    // half the time extremes or small values, otherwise the full range
    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0:       return t_coord'(32767);
            1:       return t_coord'(-32768);
            2, 3, 4: return t_coord'(int'($urandom_range(511)) - 256);
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic send_point(input t_coord x, input t_coord y, input t_coord z,
                              input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_bus.valid      = 1'b1;
        pt_bus.coord_x    = x;
        pt_bus.coord_y    = y;
        pt_bus.coord_z    = z;
        pt_bus.last_point = last;
        do @(posedge i_clk); while (!pt_bus.ready);
        @(negedge i_clk);
    endtask

    // stop sending, let every sum come back and the pipeline empty
    task automatic settle();
        pt_bus.valid = 1'b0;
        while (sb.pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_order(input t_order value);
        cfg_bus.valid      = 1'b1;
        cfg_bus.diff_order = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin
        int path_left;
        sb                 = new(DIMS);
        path_left          = 0;
        src_idle_pct       = 0;
        sink_idle_pct      = 0;
        i_rst_n            = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.diff_order = ORDER_RESET;
        pt_bus.valid       = 1'b0;
        pt_bus.coord_x     = '0;
        pt_bus.coord_y     = '0;
        pt_bus.coord_z     = '0;
        pt_bus.last_point  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single-point path under the reset order
        send_point(0, 0, 0, 1'b1);
        // largest jerk on every axis
        send_point(32767, -32768, 32767, 1'b0);
        send_point(-32768, 32767, -32768, 1'b0);
        send_point(32767, -32768, 32767, 1'b0);
        send_point(-32768, 32767, -32768, 1'b1);
        settle();
        // velocity across the full range
        write_order(ORDER_VEL);
        send_point(-32768, 0, 32767, 1'b0);
        send_point(32767, -1, -32768, 1'b1);
        settle();
        // order zero acts as velocity
        write_order(ORDER_ZERO);
        send_point(1, 2, 3, 1'b0);
        send_point(-1, -2, -3, 1'b0);
        send_point(0, 32767, -32768, 1'b1);
        settle();
        // acceleration on a path too short for a window
        write_order(ORDER_ACC);
        send_point(100, 200, 300, 1'b0);
        send_point(5, 5, 5, 1'b1);
        // order changed in the middle of a path
        send_point(10, -10, 0, 1'b0);
        send_point(20, -20, 0, 1'b0);
        send_point(40, -40, 5, 1'b0);
        settle();
        write_order(ORDER_JERK);
        send_point(80, -80, 10, 1'b0);
        send_point(-32768, 32767, -32768, 1'b1);
        settle();

        // random paths; a phase may stop in the middle of a path
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                src_idle_pct  = 19;
                sink_idle_pct = 59;
            end else if (phase < 2 * PHASES / 3) begin
                src_idle_pct  = 59;
                sink_idle_pct = 19;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_order(t_order'(phase % 4));
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (path_left == 0) begin
                    path_left = ($urandom_range(7) == 0) ? $urandom_range(30, 8)
                                                         : $urandom_range(6, 1);
                end
                path_left--;
                send_point(pick_coord(), pick_coord(), pick_coord(), path_left == 0);
            end
            settle();
        end

        if (sb.fail_count == 0) begin
            $display("path_difference_energy test passed");
        end else begin
            $display("path_difference_energy test failed");
        end
        $finish;
    end

endmodule
